// ===== design/rvpp_pkg.sv =====
// Package for the RGB(A) to display pixel packer: item types, configuration
// types, register indexes and the mask leading-one encoder.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none

package rvpp_pkg;

  // Number of color channels and their positions in channel vectors.
  localparam int unsigned NumChan = 3;
  localparam int unsigned ChRed   = 0;
  localparam int unsigned ChGreen = 1;
  localparam int unsigned ChBlue  = 2;

  // Source sample width, display word width and narrow display word width.
  localparam int unsigned SampleW = 8;
  localparam int unsigned WordW   = 32;
  localparam int unsigned NarrowW = 16;

  // Bit positions used by the channel placement, and the alpha and rounding constants of the blend.
  localparam logic [4:0] WideBase   = 5'd7;
  localparam logic [4:0] NarrowTop  = 5'd15;
  localparam logic [7:0] AlphaFull  = 8'hff;
  localparam logic [7:0] AlphaNone  = 8'h00;
  localparam logic [16:0] BlendRound = 17'd128;

  // Configuration register indexes, in register-list order.
  typedef enum logic [2:0] {
    REG_WIDE_MODE   = 3'd0,
    REG_ALPHA_USED  = 3'd1,
    REG_RED_MASK    = 3'd2,
    REG_GREEN_MASK  = 3'd3,
    REG_BLUE_MASK   = 3'd4,
    REG_BACK_RED    = 3'd5,
    REG_BACK_GREEN  = 3'd6,
    REG_BACK_BLUE   = 3'd7
  } cfg_reg_e;

  // Position of the most significant set bit of a mask.
  typedef struct packed {
    logic       present;  // mask is nonzero
    logic [4:0] idx;      // index of the top set bit when present
  } msb_t;

  // Input item and result item payloads.
  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [31:0] pixel_word;
    logic        shift_error;
  } pix_out_t;

  // Configuration state seen by the datapath. The top-bit positions are
  // kept next to the masks so the datapath never searches a mask.
  typedef struct packed {
    logic                             wide_mode;
    logic                             alpha_used;
    logic [NumChan-1:0][WordW-1:0]    mask;
    msb_t [NumChan-1:0]               msb;
    logic [NumChan-1:0][SampleW-1:0]  back;
  } cfg_t;

  // Leading-one encoder for a 32-bit mask.
  function automatic msb_t find_msb(logic [WordW-1:0] v);
    msb_t r;
    r.present = 1'b0;
    r.idx     = 5'd0;
    for (int i = 0; i < WordW; i++) begin
      if (v[i]) begin
        r.present = 1'b1;
        r.idx     = 5'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/rvpp_stream_if.sv =====
// Valid/ready channel interfaces for pixel items entering and leaving the
// packer. Depends on rvpp_pkg for the payload types.
`default_nettype none

interface rvpp_in_if;
  logic              valid;
  logic              ready;
  rvpp_pkg::pix_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rvpp_out_if;
  logic               valid;
  logic               ready;
  rvpp_pkg::pix_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/rvpp_cfg_regs.sv =====
// Configuration register bank of the pixel packer. Mask writes also record
// the top set bit of the new mask. Depends on rvpp_pkg.
`default_nettype none

module rvpp_cfg_regs (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [2:0]           cfg_idx_i,
  input  wire logic [31:0]          cfg_wdata_i,
  output rvpp_pkg::cfg_t            cfg_o
);

  rvpp_pkg::cfg_t   cfg_q, cfg_d;
  rvpp_pkg::cfg_reg_e reg_sel;
  rvpp_pkg::msb_t   wdata_msb;

  assign reg_sel   = rvpp_pkg::cfg_reg_e'(cfg_idx_i);
  assign wdata_msb = rvpp_pkg::find_msb(cfg_wdata_i);

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_sel)
        rvpp_pkg::REG_WIDE_MODE:  cfg_d.wide_mode  = cfg_wdata_i[0];
        rvpp_pkg::REG_ALPHA_USED: cfg_d.alpha_used = cfg_wdata_i[0];
        rvpp_pkg::REG_RED_MASK: begin
          cfg_d.mask[rvpp_pkg::ChRed] = cfg_wdata_i;
          cfg_d.msb[rvpp_pkg::ChRed]  = wdata_msb;
        end
        rvpp_pkg::REG_GREEN_MASK: begin
          cfg_d.mask[rvpp_pkg::ChGreen] = cfg_wdata_i;
          cfg_d.msb[rvpp_pkg::ChGreen]  = wdata_msb;
        end
        rvpp_pkg::REG_BLUE_MASK: begin
          cfg_d.mask[rvpp_pkg::ChBlue] = cfg_wdata_i;
          cfg_d.msb[rvpp_pkg::ChBlue]  = wdata_msb;
        end
        rvpp_pkg::REG_BACK_RED:   cfg_d.back[rvpp_pkg::ChRed]   = cfg_wdata_i[7:0];
        rvpp_pkg::REG_BACK_GREEN: cfg_d.back[rvpp_pkg::ChGreen] = cfg_wdata_i[7:0];
        rvpp_pkg::REG_BACK_BLUE:  cfg_d.back[rvpp_pkg::ChBlue]  = cfg_wdata_i[7:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  // Reset gives 24-bit RGB masks, wide mode, no alpha, black background.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wide_mode  <= 1'b1;
      cfg_q.alpha_used <= 1'b0;
      cfg_q.mask[rvpp_pkg::ChRed]   <= 32'h00ff_0000;
      cfg_q.mask[rvpp_pkg::ChGreen] <= 32'h0000_ff00;
      cfg_q.mask[rvpp_pkg::ChBlue]  <= 32'h0000_00ff;
      cfg_q.msb[rvpp_pkg::ChRed]    <= '{present: 1'b1, idx: 5'd23};
      cfg_q.msb[rvpp_pkg::ChGreen]  <= '{present: 1'b1, idx: 5'd15};
      cfg_q.msb[rvpp_pkg::ChBlue]   <= '{present: 1'b1, idx: 5'd7};
      cfg_q.back <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== design/rvpp_blend.sv =====
// Alpha compositing of one 8-bit sample over a background sample, with
// rounded division by 255. Depends on rvpp_pkg.
`default_nettype none

module rvpp_blend (
  input  wire logic       en_i,
  input  wire logic [7:0] fg_i,
  input  wire logic [7:0] bg_i,
  input  wire logic [7:0] alpha_i,
  output logic      [7:0] sample_o
);

  logic [15:0] fg_prod;
  logic [15:0] bg_prod;
  logic [16:0] t_sum;
  logic [15:0] t_fold;

  // t = fg*a + bg*(255-a) + 128 stays below 2^16.
  assign fg_prod = 16'(fg_i) * 16'(alpha_i);
  assign bg_prod = 16'(bg_i) * {8'h00, ~alpha_i};
  assign t_sum   = 17'(fg_prod) + 17'(bg_prod) + rvpp_pkg::BlendRound;
  // (t + (t >> 8)) >> 8 is the rounded quotient by 255.
  assign t_fold  = t_sum[15:0] + {8'h00, t_sum[15:8]};

  // Disabled or opaque alpha passes fg, transparent alpha passes bg.
  always_comb begin
    priority if (!en_i)                        sample_o = fg_i;
    else if (alpha_i == rvpp_pkg::AlphaFull)   sample_o = fg_i;
    else if (alpha_i == rvpp_pkg::AlphaNone)   sample_o = bg_i;
    else                                       sample_o = t_fold[15:8];
  end

endmodule

`default_nettype wire

// ===== design/rvpp_place.sv =====
// Places three composited samples into the display word using the mask
// top-bit positions, and flags masks that need a negative shift or, in
// wide mode, are zero. Depends on rvpp_pkg.
`default_nettype none

module rvpp_place (
  input  wire rvpp_pkg::cfg_t             cfg_i,
  input  wire logic [2:0][7:0]            sample_i,
  output rvpp_pkg::pix_out_t              result_o
);

  logic [2:0][31:0] wide_part;
  logic [2:0][15:0] narrow_part;
  logic [2:0]       wide_bad;
  logic [2:0]       narrow_bad;

  // Per-channel shifts, all channels independent.
  always_comb begin
    for (int k = 0; k < rvpp_pkg::NumChan; k++) begin
      logic [4:0]  lsh;
      logic [3:0]  rsh;
      logic [15:0] widened;
      lsh = cfg_i.msb[k].idx - rvpp_pkg::WideBase;
      rsh = rvpp_pkg::NarrowTop[3:0] - cfg_i.msb[k].idx[3:0];
      widened = {sample_i[k], 8'h00};

      // Wide mode: shift left by top bit minus 7; a zero mask is an error.
      wide_bad[k]  = !cfg_i.msb[k].present || (cfg_i.msb[k].idx < rvpp_pkg::WideBase);
      wide_part[k] = 32'(sample_i[k]) << lsh;

      // Narrow mode: shift right by 15 minus top bit; a zero mask adds nothing.
      narrow_bad[k] = cfg_i.msb[k].present && (cfg_i.msb[k].idx > rvpp_pkg::NarrowTop);
      if (cfg_i.msb[k].present) begin
        narrow_part[k] = (widened >> rsh) & cfg_i.mask[k][15:0];
      end else begin
        narrow_part[k] = 16'h0000;
      end
    end
  end

  // Merge channels and apply the error rule.
  always_comb begin
    logic        err;
    logic [31:0] word;
    if (cfg_i.wide_mode) begin
      err  = |wide_bad;
      word = wide_part[rvpp_pkg::ChRed] | wide_part[rvpp_pkg::ChGreen]
           | wide_part[rvpp_pkg::ChBlue];
    end else begin
      err  = |narrow_bad;
      word = {16'h0000, narrow_part[rvpp_pkg::ChRed] | narrow_part[rvpp_pkg::ChGreen]
                        | narrow_part[rvpp_pkg::ChBlue]};
    end
    result_o.shift_error = err;
    result_o.pixel_word  = err ? 32'h0000_0000 : word;
  end

endmodule

`default_nettype wire

// ===== design/rgba_to_visual_pixel_pack_unit.sv =====
// Top level of the RGB(A) to display pixel packer: config bank, input
// register, blend and placement logic, result register.
// Depends on rvpp_pkg, rvpp_stream_if, rvpp_cfg_regs, rvpp_blend, rvpp_place.
//
//   channel   direction  handshake     payload
//   pix_i     in         valid/ready   in_red, in_green, in_blue, in_alpha
//   pix_o     out        valid/ready   pixel_word, shift_error
//   cfg       in         cfg_we_i      cfg_idx_i, cfg_wdata_i (write only)
//
// One item per clock sustained while the output is not stalled; an accepted
// item passes through the input register, then the result register, from
// which its result is offered.
// Compositing and placement happen between those two registers.
// Reset clears both valid flags and loads the register defaults.
// A stalled result holds in the result register while the input register
// still takes one more item; input ready drops only when both are full.
`default_nettype none

module rgba_to_visual_pixel_pack_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  rvpp_in_if.sink          pix_i,
  rvpp_out_if.source       pix_o
);

  rvpp_pkg::cfg_t     cfg;
  logic               in_valid_q;
  rvpp_pkg::pix_in_t  in_data_q;
  logic               out_valid_q;
  rvpp_pkg::pix_out_t out_data_q;
  logic               out_free;
  logic               in_free;
  logic [2:0][7:0]    fg;
  logic [2:0][7:0]    bg;
  logic [2:0][7:0]    blended;
  rvpp_pkg::pix_out_t result;

  rvpp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Handshake: the result register frees when empty or taken; the input
  // register frees when empty or moving on.
  assign out_free    = !out_valid_q || pix_o.ready;
  assign in_free     = !in_valid_q || out_free;
  assign pix_i.ready = in_free;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_free) begin
      in_valid_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_free && pix_i.valid) begin
      in_data_q <= pix_i.data;
    end
  end

  // Compositing per channel.
  assign fg[rvpp_pkg::ChRed]   = in_data_q.in_red;
  assign fg[rvpp_pkg::ChGreen] = in_data_q.in_green;
  assign fg[rvpp_pkg::ChBlue]  = in_data_q.in_blue;
  assign bg = cfg.back;

  for (genvar k = 0; k < rvpp_pkg::NumChan; k++) begin : g_blend
    rvpp_blend u_blend (
      .en_i     (cfg.alpha_used),
      .fg_i     (fg[k]),
      .bg_i     (bg[k]),
      .alpha_i  (in_data_q.in_alpha),
      .sample_o (blended[k])
    );
  end

  rvpp_place u_place (
    .cfg_i    (cfg),
    .sample_i (blended),
    .result_o (result)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && in_valid_q) begin
      out_data_q <= result;
    end
  end

  assign pix_o.valid = out_valid_q;
  assign pix_o.data  = out_data_q;

  // Input ready is low whenever both registers hold items and the output stalls.
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !pix_o.ready) |-> !pix_i.ready)
    else $error("input ready high with both stages full and output stalled");

  // An item in the input register reaches the result register when it frees.
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_free) |=> out_valid_q)
    else $error("item lost between input and result register");

  // A flagged result carries a zero pixel.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.shift_error) |-> (out_data_q.pixel_word == 32'h0000_0000))
    else $error("shift error with nonzero pixel");

  // In 16-bit mode only the low half of the word can be set.
  a_narrow_hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !cfg.wide_mode) |-> (out_data_q.pixel_word[31:16] == 16'h0000))
    else $error("16-bit mode result has upper bits set");

endmodule

`default_nettype wire
